// ===== src/ocbc_pkg.sv =====
package ocbc_pkg;

    // Fixed field widths
    localparam int CW     = 21;
    localparam int LW     = 5;
    localparam int MODE_W = 2;

    localparam int DEFAULT_MAX_LEVEL = 19;

    // Balance mode codes; the unused code acts as full corner balance
    localparam logic [MODE_W-1:0] MODE_FACE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_EDGE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FULL = 2'd2;

    // Control beat into the level kernel
    typedef struct packed {
        logic              valid;
        logic [LW-1:0]     level;
        logic [MODE_W-1:0] mode;
    } kctl_t;

    // Result beat out of the level kernel
    typedef struct packed {
        logic          valid;
        logic [LW-1:0] level;
    } kres_t;

endpackage

// ===== src/ocbc_kernel.sv =====
module ocbc_kernel #(
    parameter int MAX_LEVEL = ocbc_pkg::DEFAULT_MAX_LEVEL,
    parameter int UW        = 23
) (
    input  logic            clk,
    input  logic            rst_n,
    input  ocbc_pkg::kctl_t ctl,
    input  logic [UW-1:0]   dx,
    input  logic [UW-1:0]   dy,
    input  logic [UW-1:0]   dz,
    output ocbc_pkg::kres_t res
);

    localparam int SHW = $clog2(MAX_LEVEL + 1);
    localparam int VW  = UW + 2;
    localparam int RW  = $clog2(VW);
    localparam int KW  = (RW > ocbc_pkg::LW) ? RW : ocbc_pkg::LW;

    // Stage 1: scale distances to q's side length, round up to even
    logic [SHW-1:0] sh;
    logic [UW-1:0]  ux, uy, uz, ux_p1, uy_p1, uz_p1;
    logic [UW-1:0]  ex, ey, ez, dm, f;
    logic           is_face, is_full, rawzero;

    always_comb
    begin
        sh      = SHW'(MAX_LEVEL) - SHW'(ctl.level);
        ux      = dx >> sh;
        uy      = dy >> sh;
        uz      = dz >> sh;
        ux_p1   = ux + UW'(1);
        uy_p1   = uy + UW'(1);
        uz_p1   = uz + UW'(1);
        ex      = {ux_p1[UW-1:1], 1'b0};
        ey      = {uy_p1[UW-1:1], 1'b0};
        ez      = {uz_p1[UW-1:1], 1'b0};
        dm      = (dx > dy) ? dx : dy;
        dm      = (dz > dm) ? dz : dm;
        f       = (dm >> sh) + UW'(1);
        is_face = (ctl.mode == ocbc_pkg::MODE_FACE);
        is_full = (ctl.mode != ocbc_pkg::MODE_FACE) && (ctl.mode != ocbc_pkg::MODE_EDGE);
        rawzero = (dx == '0) && (dy == '0) && (dz == '0);
    end

    logic                    k1_valid_reg;
    logic [ocbc_pkg::LW-1:0] k1_level_reg;
    logic                    k1_face_reg, k1_full_reg, k1_rawzero_reg;
    logic [UW-1:0]           k1_ex_reg, k1_ey_reg, k1_ez_reg, k1_f_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k1_valid_reg <= 1'b0;
        end
        else
        begin
            k1_valid_reg <= ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        k1_level_reg   <= ctl.level;
        k1_face_reg    <= is_face;
        k1_full_reg    <= is_full;
        k1_rawzero_reg <= rawzero;
        k1_ex_reg      <= ex;
        k1_ey_reg      <= ey;
        k1_ez_reg      <= ez;
        k1_f_reg       <= f;
    end

    // Stage 2: fold terms into one word whose msb is the level drop
    logic [VW-1:0] ta, tb, tc, orv, sumv, v_next;

    always_comb
    begin
        if (k1_face_reg)
        begin
            ta = VW'(k1_ey_reg) + VW'(k1_ez_reg);
            tb = VW'(k1_ez_reg) + VW'(k1_ex_reg);
            tc = VW'(k1_ex_reg) + VW'(k1_ey_reg);
        end
        else
        begin
            ta = VW'(k1_ex_reg);
            tb = VW'(k1_ey_reg);
            tc = VW'(k1_ez_reg);
        end
        orv  = ta | tb | tc;
        sumv = ta + tb + tc - orv;
        if (k1_full_reg)
            v_next = VW'(k1_f_reg);
        else
            v_next = orv | sumv;
    end

    logic                    k2_valid_reg;
    logic [ocbc_pkg::LW-1:0] k2_level_reg;
    logic                    k2_full_reg, k2_rawzero_reg;
    logic [VW-1:0]           k2_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k2_valid_reg <= 1'b0;
        end
        else
        begin
            k2_valid_reg <= k1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        k2_level_reg   <= k1_level_reg;
        k2_full_reg    <= k1_full_reg;
        k2_rawzero_reg <= k1_rawzero_reg;
        k2_v_reg       <= v_next;
    end

    // Stage 3: msb search and level subtract, floored at zero
    logic [RW-1:0]           r;
    logic [KW-1:0]           lev_k, r_k;
    logic [ocbc_pkg::LW-1:0] blev_next;

    always_comb
    begin
        r = '0;
        for (int i = 0; i < VW; i++)
        begin
            if (k2_v_reg[i])
                r = RW'(i);
        end
        lev_k = KW'(k2_level_reg);
        r_k   = KW'(r);
        if (!k2_full_reg && k2_rawzero_reg)
            blev_next = k2_level_reg;
        else if (k2_v_reg == '0)
            blev_next = k2_level_reg + ocbc_pkg::LW'(1);
        else if (r_k >= lev_k)
            blev_next = '0;
        else
            blev_next = ocbc_pkg::LW'(lev_k - r_k);
    end

    logic                    res_valid_reg;
    logic [ocbc_pkg::LW-1:0] res_level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= k2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        res_level_reg <= blev_next;
    end

    assign res.valid = res_valid_reg;
    assign res.level = res_level_reg;

endmodule

// ===== src/octant_corner_balance_check.sv =====
// A result is strobed on done once its start beat has passed through every stage.
// Throughput: one beat per cycle; busy stays low, the five-stage pipeline
// (distance, scale, fold, msb search, output) takes a beat every clock.
// The receiver cannot stall, so no beat is ever held back.
// Reset clears the stage valid bits and sets balance mode to full corner.
module octant_corner_balance_check #(
    parameter int MAX_LEVEL = ocbc_pkg::DEFAULT_MAX_LEVEL
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [ocbc_pkg::MODE_W-1:0]         cfg_wr_data,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [ocbc_pkg::CW-1:0]      q_x,
    input  logic signed [ocbc_pkg::CW-1:0]      q_y,
    input  logic signed [ocbc_pkg::CW-1:0]      q_z,
    input  logic [ocbc_pkg::LW-1:0]             q_level,
    input  logic signed [ocbc_pkg::CW-1:0]      p_x,
    input  logic signed [ocbc_pkg::CW-1:0]      p_y,
    input  logic signed [ocbc_pkg::CW-1:0]      p_z,
    input  logic [ocbc_pkg::LW-1:0]             p_level,
    input  logic [2:0]                          corner_id,
    output logic                                done,
    output logic                                consistent,
    output logic signed [ocbc_pkg::CW-1:0]      out_x,
    output logic signed [ocbc_pkg::CW-1:0]      out_y,
    output logic signed [ocbc_pkg::CW-1:0]      out_z,
    output logic [ocbc_pkg::LW-1:0]             out_level
);

    localparam int CW  = ocbc_pkg::CW;
    localparam int LW  = ocbc_pkg::LW;
    localparam int SHW = $clog2(MAX_LEVEL + 1);
    localparam int DW  = ((CW > MAX_LEVEL) ? CW : MAX_LEVEL) + 2;
    localparam int UW  = DW - 1;

    localparam logic [LW-1:0]  LEV_TOP = LW'(MAX_LEVEL - 1);
    localparam logic [SHW-1:0] ML_S    = SHW'(MAX_LEVEL);

    // Balance mode register
    logic [ocbc_pkg::MODE_W-1:0] mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= ocbc_pkg::MODE_FULL;
        else if (cfg_wr_en)
            mode_reg <= cfg_wr_data;
    end

    assign busy = 1'b0;

    logic accept;
    assign accept = start && !busy;

    // Stage 1: clamp levels, axis distances to p's corner
    logic [LW-1:0]          qlev_c, plev_c;
    logic [SHW-1:0]         qsh, psh;
    logic signed [DW-1:0]   qlen, plen;
    logic signed [CW-1:0]   q_in [3];
    logic signed [CW-1:0]   p_in [3];
    logic signed [DW-1:0]   qe, pe, dd;
    logic [UW-1:0]          d_next [3];

    always_comb
    begin
        q_in[0] = q_x;
        q_in[1] = q_y;
        q_in[2] = q_z;
        p_in[0] = p_x;
        p_in[1] = p_y;
        p_in[2] = p_z;
        qlev_c  = (q_level > LEV_TOP) ? LEV_TOP : q_level;
        plev_c  = (p_level > LEV_TOP) ? LEV_TOP : p_level;
        qsh     = ML_S - SHW'(qlev_c);
        psh     = ML_S - SHW'(plev_c);
        qlen    = DW'(1) << qsh;
        plen    = DW'(1) << psh;
        qe      = '0;
        pe      = '0;
        dd      = '0;
        for (int i = 0; i < 3; i++)
        begin
            qe = DW'(q_in[i]);
            pe = DW'(p_in[i]);
            if (corner_id[i])
                dd = (qe - pe) + (qlen - plen);
            else
                dd = pe - qe;
            // q on the wrong side of the corner counts as touching
            d_next[i] = dd[DW-1] ? '0 : dd[UW-1:0];
        end
    end

    logic                 s1_valid_reg;
    logic                 s1_refine_reg;
    logic [LW-1:0]        s1_qlev_reg, s1_plev_reg, s1_plev_raw_reg;
    logic [2:0]           s1_corner_reg;
    logic [UW-1:0]        s1_d_reg [3];
    logic signed [CW-1:0] s1_q_reg [3];
    logic signed [CW-1:0] s1_p_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        s1_refine_reg   <= qlev_c > plev_c;
        s1_qlev_reg     <= qlev_c;
        s1_plev_reg     <= plev_c;
        s1_plev_raw_reg <= p_level;
        s1_corner_reg   <= corner_id;
        for (int i = 0; i < 3; i++)
        begin
            s1_d_reg[i] <= d_next[i];
            s1_q_reg[i] <= q_in[i];
            s1_p_reg[i] <= p_in[i];
        end
    end

    // Level kernel: stages 2 to 4
    ocbc_pkg::kctl_t kctl;
    ocbc_pkg::kres_t kres;

    assign kctl.valid = s1_valid_reg;
    assign kctl.level = s1_qlev_reg;
    assign kctl.mode  = mode_reg;

    ocbc_kernel #(
        .MAX_LEVEL (MAX_LEVEL),
        .UW        (UW)
    ) u_kernel (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (kctl),
        .dx    (s1_d_reg[0]),
        .dy    (s1_d_reg[1]),
        .dz    (s1_d_reg[2]),
        .res   (kres)
    );

    // Side pipe: shifted position of q and the echo fields
    logic signed [CW-1:0] pos_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (s1_corner_reg[i])
                pos_next[i] = s1_q_reg[i] - $signed(s1_d_reg[i][CW-1:0]);
            else
                pos_next[i] = s1_q_reg[i] + $signed(s1_d_reg[i][CW-1:0]);
        end
    end

    logic                 sp_refine_reg [3];
    logic [LW-1:0]        sp_plev_reg [3];
    logic [LW-1:0]        sp_plev_raw_reg [3];
    logic signed [CW-1:0] sp_pos_reg [3][3];
    logic signed [CW-1:0] sp_p_reg [3][3];

    always_ff @(posedge clk)
    begin
        sp_refine_reg[0]   <= s1_refine_reg;
        sp_plev_reg[0]     <= s1_plev_reg;
        sp_plev_raw_reg[0] <= s1_plev_raw_reg;
        for (int a = 0; a < 3; a++)
        begin
            sp_pos_reg[0][a] <= pos_next[a];
            sp_p_reg[0][a]   <= s1_p_reg[a];
        end
        for (int s = 1; s < 3; s++)
        begin
            sp_refine_reg[s]   <= sp_refine_reg[s-1];
            sp_plev_reg[s]     <= sp_plev_reg[s-1];
            sp_plev_raw_reg[s] <= sp_plev_raw_reg[s-1];
            for (int a = 0; a < 3; a++)
            begin
                sp_pos_reg[s][a] <= sp_pos_reg[s-1][a];
                sp_p_reg[s][a]   <= sp_p_reg[s-1][a];
            end
        end
    end

    // Stage 5: decide and mask to the required level
    logic [SHW-1:0]       osh;
    logic [CW-1:0]        mask;
    logic                 cons_next;
    logic signed [CW-1:0] ox_next, oy_next, oz_next;
    logic [LW-1:0]        olev_next;

    always_comb
    begin
        osh       = ML_S - SHW'(kres.level);
        mask      = {CW{1'b1}} << osh;
        cons_next = !sp_refine_reg[2] || (kres.level <= sp_plev_reg[2]);
        if (cons_next)
        begin
            ox_next   = sp_p_reg[2][0];
            oy_next   = sp_p_reg[2][1];
            oz_next   = sp_p_reg[2][2];
            olev_next = sp_plev_raw_reg[2];
        end
        else
        begin
            ox_next   = sp_pos_reg[2][0] & $signed(mask);
            oy_next   = sp_pos_reg[2][1] & $signed(mask);
            oz_next   = sp_pos_reg[2][2] & $signed(mask);
            olev_next = kres.level;
        end
    end

    logic                 done_reg;
    logic                 consistent_reg;
    logic signed [CW-1:0] out_x_reg, out_y_reg, out_z_reg;
    logic [LW-1:0]        out_level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= kres.valid;
    end

    always_ff @(posedge clk)
    begin
        consistent_reg <= cons_next;
        out_x_reg      <= ox_next;
        out_y_reg      <= oy_next;
        out_z_reg      <= oz_next;
        out_level_reg  <= olev_next;
    end

    assign done       = done_reg;
    assign consistent = consistent_reg;
    assign out_x      = out_x_reg;
    assign out_y      = out_y_reg;
    assign out_z      = out_z_reg;
    assign out_level  = out_level_reg;

    // Every taken beat comes out on done after the s1, kernel and output registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##5 done)
        else $error("beat did not complete in five cycles");

    // A refined result is always finer than the root level
    a_refine_level: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !consistent) |-> (out_level != '0))
        else $error("refined result at level zero");

    // A consistent result echoes p unchanged
    a_echo: assert property (@(posedge clk) disable iff (!rst_n)
        (done && consistent) |-> (out_x == $past(p_x, 5) && out_y == $past(p_y, 5)
                                  && out_z == $past(p_z, 5)
                                  && out_level == $past(p_level, 5)))
        else $error("consistent result does not echo p");

endmodule

// ===== verif/tb_octant_corner_balance_check.sv =====
`timescale 1ns / 1ps

module tb_octant_corner_balance_check;

    import ocbc_pkg::*;

    localparam int MAX_LVL      = DEFAULT_MAX_LEVEL;
    localparam int LATENCY      = 5;
    localparam int SETTLE       = LATENCY + 5;
    localparam int WATCHDOG     = 4000;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_BEATS  = 250;
    localparam int REPORT_CAP   = 100;
    localparam int CMAX         = 1048575;
    localparam int CMIN         = -1048576;
    // unused mode code, behaves as full corner balance
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    typedef struct packed {
        logic [CW-1:0] q_x;
        logic [CW-1:0] q_y;
        logic [CW-1:0] q_z;
        logic [LW-1:0] q_level;
        logic [CW-1:0] p_x;
        logic [CW-1:0] p_y;
        logic [CW-1:0] p_z;
        logic [LW-1:0] p_level;
        logic [2:0]    corner_id;
    } octant_pair_t;

    typedef struct packed {
        logic          consistent;
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] z;
        logic [LW-1:0] level;
    } balance_t;

    logic clk;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [MODE_W-1:0] cfg_wr_data = MODE_FULL;
    logic start = 1'b0;
    logic busy;
    logic signed [CW-1:0] q_x = '0;
    logic signed [CW-1:0] q_y = '0;
    logic signed [CW-1:0] q_z = '0;
    logic [LW-1:0] q_level = '0;
    logic signed [CW-1:0] p_x = '0;
    logic signed [CW-1:0] p_y = '0;
    logic signed [CW-1:0] p_z = '0;
    logic [LW-1:0] p_level = '0;
    logic [2:0] corner_id = '0;
    logic done;
    logic consistent;
    logic signed [CW-1:0] out_x;
    logic signed [CW-1:0] out_y;
    logic signed [CW-1:0] out_z;
    logic [LW-1:0] out_level;

    octant_pair_t pair_queue[$];
    balance_t     balance_due[$];
    logic [MODE_W-1:0] mode_now = MODE_FULL;
    int sender_idle_pct = 0;
    int beats_sent = 0;
    int next_hold = 300;
    bit holding = 1'b0;
    int quiet_cycles = 0;
    int mismatches = 0;
    int phase_idle[NUM_PHASES] = '{0, 84, 21, 0, 84, 21, 0, 84};
    logic [MODE_W-1:0] phase_mode[NUM_PHASES] =
        '{MODE_FULL, MODE_EDGE, MODE_FACE, MODE_SPARE,
          MODE_FULL, MODE_FACE, MODE_EDGE, MODE_SPARE};

    octant_corner_balance_check #(
        .MAX_LEVEL(MAX_LVL)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .start(start),
        .busy(busy),
        .q_x(q_x),
        .q_y(q_y),
        .q_z(q_z),
        .q_level(q_level),
        .p_x(p_x),
        .p_y(p_y),
        .p_z(p_z),
        .p_level(p_level),
        .corner_id(corner_id),
        .done(done),
        .consistent(consistent),
        .out_x(out_x),
        .out_y(out_y),
        .out_z(out_z),
        .out_level(out_level)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Balance predictor
    // ---------------------------------------------------------------

    // index of the highest set bit, -1 for zero
    function automatic int msb_index(longint unsigned v);
        int r;
        r = -1;
        while (v != 0)
        begin
            r++;
            v = v >> 1;
        end
        return r;
    endfunction

    // distance in side lengths of the level, rounded up to even
    function automatic longint unsigned even_units(longint unsigned d, int shift);
        return ((d >> shift) + 1) & ~64'd1;
    endfunction

    // coarsest level at p's position still balanced with q
    function automatic int coarsest_level(longint unsigned dx, longint unsigned dy,
                                          longint unsigned dz, int level,
                                          logic [MODE_W-1:0] mode);
        int shift, top, r;
        longint unsigned ex, ey, ez, sx, sy, sz, dmax;
        shift = MAX_LVL - level;
        if (mode == MODE_FACE || mode == MODE_EDGE)
        begin
            if (dx == 0 && dy == 0 && dz == 0)
                return level;
            ex = even_units(dx, shift);
            ey = even_units(dy, shift);
            ez = even_units(dz, shift);
            // face balance runs the edge fold on the pairwise sums
            if (mode == MODE_FACE)
            begin
                sx = ey + ez;
                sy = ez + ex;
                sz = ex + ey;
                ex = sx;
                ey = sy;
                ez = sz;
            end
            top = msb_index(ex);
            if (msb_index(ey) > top)
                top = msb_index(ey);
            if (msb_index(ez) > top)
                top = msb_index(ez);
            r = msb_index(ex + ey + ez - (ex | ey | ez));
            if (top > r)
                r = top;
        end
        else
        begin
            dmax = dx;
            if (dy > dmax)
                dmax = dy;
            if (dz > dmax)
                dmax = dz;
            r = msb_index((dmax >> shift) + 1);
        end
        return (level - r < 0) ? 0 : level - r;
    endfunction

    function automatic balance_t predict_balance(octant_pair_t a, logic [MODE_W-1:0] mode);
        balance_t b;
        int qlev, plev, blev, i;
        longint qc[3], pc[3], gap[3];
        longint qlen, plen, v;
        longint unsigned mask;
        logic [CW-1:0] spot[3];
        qc[0] = $signed(a.q_x);
        qc[1] = $signed(a.q_y);
        qc[2] = $signed(a.q_z);
        pc[0] = $signed(a.p_x);
        pc[1] = $signed(a.p_y);
        pc[2] = $signed(a.p_z);
        qlev = (a.q_level > MAX_LVL - 1) ? MAX_LVL - 1 : int'(a.q_level);
        plev = (a.p_level > MAX_LVL - 1) ? MAX_LVL - 1 : int'(a.p_level);

        // consistent result echoes p with its raw level
        b.consistent = 1'b1;
        b.x = a.p_x;
        b.y = a.p_y;
        b.z = a.p_z;
        b.level = a.p_level;
        if (qlev <= plev)
            return b;

        qlen = longint'(1) << (MAX_LVL - qlev);
        plen = longint'(1) << (MAX_LVL - plev);
        for (i = 0; i < 3; i++)
        begin
            gap[i] = a.corner_id[i] ? (qc[i] + qlen) - (pc[i] + plen) : pc[i] - qc[i];
            if (gap[i] < 0)
                gap[i] = 0;
        end

        blev = coarsest_level(gap[0], gap[1], gap[2], qlev, mode);
        if (blev <= plev)
            return b;

        // shift q back to the corner and snap to the balance level
        mask = ~((64'd1 << (MAX_LVL - blev)) - 1);
        for (i = 0; i < 3; i++)
        begin
            v = a.corner_id[i] ? qc[i] - gap[i] : qc[i] + gap[i];
            spot[i] = v[CW-1:0] & mask[CW-1:0];
        end
        b.consistent = 1'b0;
        b.x = spot[0];
        b.y = spot[1];
        b.z = spot[2];
        b.level = blev[LW-1:0];
        return b;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus construction
    // ---------------------------------------------------------------

    function automatic octant_pair_t mk_pair(int qx, int qy, int qz, int ql,
                                             int px, int py, int pz, int pl, int c);
        octant_pair_t a;
        a.q_x = CW'(qx);
        a.q_y = CW'(qy);
        a.q_z = CW'(qz);
        a.q_level = LW'(ql);
        a.p_x = CW'(px);
        a.p_y = CW'(py);
        a.p_z = CW'(pz);
        a.p_level = LW'(pl);
        a.corner_id = 3'(c);
        return a;
    endfunction

    // mostly q placed just across one of p's corners, some raw noise
    function automatic octant_pair_t random_pair();
        octant_pair_t a;
        int plev, qlev, gp, gq, i;
        longint plen, qlen, pc, d, qv;
        logic [CW-1:0] raw;
        logic [CW-1:0] pcs[3], qcs[3];
        logic [2:0] corner;
        logic [159:0] noise;
        if ($urandom_range(99) < 20)
        begin
            noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
            a = noise[$bits(octant_pair_t)-1:0];
            return a;
        end

        plev = $urandom_range(0, MAX_LVL - 3);
        qlev = $urandom_range(plev + 1, MAX_LVL - 1);
        case ($urandom_range(15))
            0: qlev = $urandom_range(MAX_LVL, 31);
            1: qlev = $urandom_range(0, plev);
            2: plev = $urandom_range(MAX_LVL, 31);
            default: ;
        endcase
        gp = (plev > MAX_LVL - 1) ? MAX_LVL - 1 : plev;
        gq = (qlev > MAX_LVL - 1) ? MAX_LVL - 1 : qlev;
        plen = longint'(1) << (MAX_LVL - gp);
        qlen = longint'(1) << (MAX_LVL - gq);
        corner = 3'($urandom);

        for (i = 0; i < 3; i++)
        begin
            raw = CW'($urandom);
            pc = longint'($signed(raw));
            pc = pc & ~(plen - 1);
            case ($urandom_range(5))
                0: d = 0;
                1: d = longint'($urandom_range(1, 4)) * qlen;
                2: d = longint'($urandom_range(0, 32'(8 * qlen)));   // unaligned
                3: d = -longint'($urandom_range(1, 32'(2 * qlen))); // q overlaps p
                4: d = longint'($urandom_range(0, 32'(plen))) * 2;
                default: d = qlen;
            endcase
            qv = corner[i] ? pc + plen - qlen + d : pc - d;
            pcs[i] = pc[CW-1:0];
            qcs[i] = qv[CW-1:0];
        end

        a.q_x = qcs[0];
        a.q_y = qcs[1];
        a.q_z = qcs[2];
        a.q_level = LW'(qlev);
        a.p_x = pcs[0];
        a.p_y = pcs[1];
        a.p_z = pcs[2];
        a.p_level = LW'(plev);
        a.corner_id = corner;
        return a;
    endfunction

    // ---------------------------------------------------------------
    // Configuration tracking
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_now <= MODE_FULL;
        else if (cfg_wr_en)
            mode_now <= cfg_wr_data;
    end

    // ---------------------------------------------------------------
    // Driver: one beat per handshake, random sender gaps
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        octant_pair_t nxt;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (!start || !busy)
        begin
            // periodic hold-off until every result is back
            if (holding && balance_due.size() == 0)
                holding = 1'b0;
            if (!holding && beats_sent == next_hold)
            begin
                holding = 1'b1;
                next_hold += 500;
            end

            if (holding || pair_queue.size() == 0 || $urandom_range(99) < sender_idle_pct)
            begin
                start <= 1'b0;
            end
            else
            begin
                nxt = pair_queue.pop_front();
                q_x <= nxt.q_x;
                q_y <= nxt.q_y;
                q_z <= nxt.q_z;
                q_level <= nxt.q_level;
                p_x <= nxt.p_x;
                p_y <= nxt.p_y;
                p_z <= nxt.p_z;
                p_level <= nxt.p_level;
                corner_id <= nxt.corner_id;
                start <= 1'b1;
                beats_sent++;
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: predict on accept, check on done, watchdog
    // ---------------------------------------------------------------
    task automatic check_field(string name, logic [CW-1:0] want, logic [CW-1:0] got);
        if (got !== want)
        begin
            if (mismatches < REPORT_CAP)
                $error("%s mismatch: expected %h, got %h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        octant_pair_t taken;
        balance_t want;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                taken = '{q_x, q_y, q_z, q_level, p_x, p_y, p_z, p_level, corner_id};
                balance_due.push_back(predict_balance(taken, mode_now));
                quiet_cycles = 0;
            end
            else if (!done)
            begin
                quiet_cycles++;
            end

            if (done)
            begin
                quiet_cycles = 0;
                if (balance_due.size() == 0)
                begin
                    if (mismatches < REPORT_CAP)
                        $error("result beat with no expected result pending");
                    mismatches++;
                end
                else
                begin
                    want = balance_due.pop_front();
                    check_field("consistent", CW'(want.consistent), CW'(consistent));
                    check_field("out_x", want.x, out_x);
                    check_field("out_y", want.y, out_y);
                    check_field("out_z", want.z, out_z);
                    check_field("out_level", CW'(want.level), CW'(out_level));
                end
            end

            if (quiet_cycles >= WATCHDOG)
            begin
                $display("tb_octant_corner_balance_check: FAIL");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------

    // all beats sent, all results back, then let the pipeline settle
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pair_queue.size() != 0 || start || balance_due.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    initial
    begin
        int ph, n;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed beats under the reset mode (full corner)
        pair_queue.push_back(mk_pair(0, 0, 0, 0, 0, 0, 0, 0, 0));
        pair_queue.push_back(mk_pair(CMAX, CMAX, CMAX, 31, CMAX, CMAX, CMAX, 31, 7));
        pair_queue.push_back(mk_pair(CMIN, CMIN, CMIN, 18, CMIN, CMIN, CMIN, 0, 0));
        // distance below q's side length
        pair_queue.push_back(mk_pair(-1, -1, -1, 18, 0, 0, 0, 1, 0));
        // q touching the high corner, zero distance on all axes
        pair_queue.push_back(mk_pair(262142, 262142, 262142, 18, 0, 0, 0, 1, 7));
        pair_queue.push_back(mk_pair(262144, 262144, 262144, 18, 0, 0, 0, 1, 7));
        // q inside p: negative distance clamps to zero
        pair_queue.push_back(mk_pair(1000, 1000, 1000, 10, 0, 0, 0, 1, 7));
        pair_queue.push_back(mk_pair(-4096, 0, 262150, 12, 0, 0, 0, 1, 4));
        // q not finer than p
        pair_queue.push_back(mk_pair(0, 0, 0, 3, 0, 0, 0, 3, 5));
        // levels beyond the deepest usable one
        pair_queue.push_back(mk_pair(-2, -2, -2, 19, 0, 0, 0, 17, 0));
        pair_queue.push_back(mk_pair(-2, -2, -2, 31, 0, 0, 0, 25, 0));
        pair_queue.push_back(mk_pair(-2, -2, -2, 30, 0, 0, 0, 19, 3));
        // coordinate extremes, wrap-around
        pair_queue.push_back(mk_pair(CMIN, 0, CMAX, 18, CMAX, CMIN, 0, 0, 6));
        pair_queue.push_back(mk_pair(-524288, 0, 0, 18, 0, 0, 0, 0, 0));
        pair_queue.push_back(mk_pair(CMAX, CMAX, CMAX, 18, 0, 0, 0, 0, 7));
        // face, edge and corner neighbors separate the modes
        pair_queue.push_back(mk_pair(-65536, -65536, -65536, 18, 0, 0, 0, 2, 0));
        pair_queue.push_back(mk_pair(-2, 0, 0, 18, 0, 0, 0, 2, 0));
        pair_queue.push_back(mk_pair(-2, -2, 0, 18, 0, 0, 0, 2, 0));
        pair_queue.push_back(mk_pair(-2, -2, -2, 18, 0, 0, 0, 2, 0));

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph != 0)
            begin
                wait_idle();
                @(posedge clk);
                cfg_wr_en <= 1'b1;
                cfg_wr_data <= phase_mode[ph];
                @(posedge clk);
                cfg_wr_en <= 1'b0;
            end
            sender_idle_pct = phase_idle[ph];
            for (n = 0; n < PHASE_BEATS; n++)
                pair_queue.push_back(random_pair());
        end

        wait_idle();
        if (mismatches == 0)
            $display("tb_octant_corner_balance_check: PASS");
        else
            $display("tb_octant_corner_balance_check: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/ocbc_pkg.sv
src/ocbc_kernel.sv
src/octant_corner_balance_check.sv
verif/tb_octant_corner_balance_check.sv
